>>> rtl/core/sdtf_pkg.sv
package sdtf_pkg;

  // Default and upper bound of the field width in characters
  localparam int unsigned MAX_FIELD_DEF = 32;
  localparam int unsigned CNT_W         = 7;   // holds any field length up to 64

  // Decimal digits of a 32-bit magnitude
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned NDIG_W     = 4;

  // Multiply-shift reciprocal of ten, exact for every 32-bit dividend
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // ASCII codes
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;

  // Style bit positions
  localparam int unsigned STYLE_ZERO_PAD   = 0;
  localparam int unsigned STYLE_LEFT_ADJ   = 1;
  localparam int unsigned STYLE_FORCE_SIGN = 2;

  typedef enum logic [1:0] {
    PAD_BEFORE,   // spaces ahead of the sign
    PAD_ZEROS,    // zeros between sign and digits
    PAD_AFTER     // spaces after the digits
  } pad_mode_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_REM,
    FR_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    PH_PRE,
    PH_SIGN,
    PH_MID,
    PH_DIGIT,
    PH_POST
  } phase_e;

  // One converted request, ready for emission; digit 0 is the most significant
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [NDIG_W-1:0]          ndig;
    logic                       sign_on;
    logic                       sign_neg;
    pad_mode_e                  mode;
    logic [CNT_W-1:0]           pad;
  } job_t;

endpackage

>>> rtl/core/sdtf_front.sv
module sdtf_front #(
  parameter int unsigned MAX_FIELD = sdtf_pkg::MAX_FIELD_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   value_i,
  input  logic [2:0]           style_bits_i,
  input  logic [5:0]           pad_width_i,
  output logic                 push_o,
  output sdtf_pkg::job_t       job_o,
  input  logic                 full_i
);

  localparam int unsigned CW = sdtf_pkg::CNT_W;
  localparam int unsigned ND = sdtf_pkg::NUM_DIGITS;

  sdtf_pkg::front_state_e state_q, state_d;

  logic [31:0]          mag_q, mag_d;
  logic [31:0]          quo_q, quo_d;
  logic [ND-1:0][3:0]   digits_q, digits_d;
  logic [sdtf_pkg::NDIG_W-1:0] ndig_q, ndig_d;
  logic                 neg_q, neg_d;
  logic [2:0]           style_q, style_d;
  logic [CW-1:0]        width_q, width_d;

  logic [63:0]          prod;
  logic [31:0]          rem;
  logic                 sign_on;
  logic [CW-1:0]        text_len;
  logic [CW-1:0]        pad;
  logic                 accept;

  // Divide by ten through the reciprocal
  assign prod = 64'(mag_q) * 64'(sdtf_pkg::DIV10_MAGIC);
  assign rem  = mag_q - ((quo_q << 3) + (quo_q << 1));

  // Field sizing from the finished digit count
  assign sign_on  = neg_q | style_q[sdtf_pkg::STYLE_FORCE_SIGN];
  assign text_len = CW'(ndig_q) + CW'(sign_on);
  assign pad      = (width_q > text_len) ? (width_q - text_len) : '0;

  assign in_ready_o = (state_q == sdtf_pkg::FR_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    job_o.digits   = digits_q;
    job_o.ndig     = ndig_q;
    job_o.sign_on  = sign_on;
    job_o.sign_neg = neg_q;
    job_o.pad      = pad;
    if (style_q[sdtf_pkg::STYLE_LEFT_ADJ]) begin
      job_o.mode = sdtf_pkg::PAD_AFTER;
    end else if (style_q[sdtf_pkg::STYLE_ZERO_PAD]) begin
      job_o.mode = sdtf_pkg::PAD_ZEROS;
    end else begin
      job_o.mode = sdtf_pkg::PAD_BEFORE;
    end
  end

  // Sequence the conversion: one multiply state, then one digit state, for each digit
  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    quo_d    = quo_q;
    digits_d = digits_q;
    ndig_d   = ndig_q;
    neg_d    = neg_q;
    style_d  = style_q;
    width_d  = width_q;
    push_o   = 1'b0;
    case (state_q)
      sdtf_pkg::FR_IDLE: begin
        if (accept) begin
          neg_d    = value_i[31];
          mag_d    = value_i[31] ? (32'd0 - 32'(value_i)) : 32'(value_i);
          style_d  = style_bits_i;
          width_d  = (7'(pad_width_i) > 7'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(pad_width_i);
          digits_d = '0;
          ndig_d   = '0;
          state_d  = sdtf_pkg::FR_MUL;
        end
      end
      sdtf_pkg::FR_MUL: begin
        quo_d   = 32'(prod >> sdtf_pkg::DIV10_SHIFT);
        state_d = sdtf_pkg::FR_REM;
      end
      sdtf_pkg::FR_REM: begin
        // shift the new digit in at the bottom; the first digit ends up deepest
        digits_d = {digits_q[ND-2:0], rem[3:0]};
        ndig_d   = ndig_q + 1'b1;
        mag_d    = quo_q;
        state_d  = (quo_q == 32'd0) ? sdtf_pkg::FR_PUSH : sdtf_pkg::FR_MUL;
      end
      sdtf_pkg::FR_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = sdtf_pkg::FR_IDLE;
        end
      end
      default: state_d = sdtf_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdtf_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    quo_q    <= quo_d;
    digits_q <= digits_d;
    ndig_q   <= ndig_d;
    neg_q    <= neg_d;
    style_q  <= style_d;
    width_q  <= width_d;
  end

  a_quo_not_above_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdtf_pkg::FR_REM) |-> (quo_q <= mag_q))
    else $error("quotient exceeds dividend");

  a_ndig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdtf_pkg::FR_PUSH) |-> (ndig_q >= 1 && ndig_q <= ND))
    else $error("digit count out of range");

endmodule

>>> rtl/core/sdtf_queue.sv
module sdtf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdtf_pkg::job_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output sdtf_pkg::job_t entry_o,
  output logic           empty_o
);

  localparam int unsigned DEPTH = sdtf_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  sdtf_pkg::job_t  mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> rtl/core/sdtf_back.sv
module sdtf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sdtf_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     text_char_o,
  output logic           final_char_o
);

  localparam int unsigned CW = sdtf_pkg::CNT_W;

  typedef struct packed {
    logic             found;
    sdtf_pkg::phase_e ph;
  } step_t;

  // Number of characters a phase contributes for this request
  function automatic logic [CW-1:0] phase_len(sdtf_pkg::job_t j, sdtf_pkg::phase_e p);
    logic [CW-1:0] len;
    len = '0;
    case (p)
      sdtf_pkg::PH_PRE:   len = (j.mode == sdtf_pkg::PAD_BEFORE) ? j.pad : '0;
      sdtf_pkg::PH_SIGN:  len = CW'(j.sign_on);
      sdtf_pkg::PH_MID:   len = (j.mode == sdtf_pkg::PAD_ZEROS) ? j.pad : '0;
      sdtf_pkg::PH_DIGIT: len = CW'(j.ndig);
      sdtf_pkg::PH_POST:  len = (j.mode == sdtf_pkg::PAD_AFTER) ? j.pad : '0;
      default:            len = '0;
    endcase
    return len;
  endfunction

  // First non-empty phase after the given one
  function automatic step_t next_phase(sdtf_pkg::job_t j, sdtf_pkg::phase_e cur);
    step_t r;
    r.found = 1'b0;
    r.ph    = sdtf_pkg::PH_POST;
    for (int i = 4; i >= 0; i--) begin
      if ((i > int'(cur)) && (phase_len(j, sdtf_pkg::phase_e'(3'(i))) != '0)) begin
        r.found = 1'b1;
        r.ph    = sdtf_pkg::phase_e'(3'(i));
      end
    end
    return r;
  endfunction

  sdtf_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             active_q, active_d;
  logic             out_valid_q, out_valid_d;
  logic [6:0]       char_q, char_d;
  logic             final_q, final_d;

  logic             emit;
  logic             last_in_phase;
  logic             is_final;
  step_t            nxt;
  step_t            first;
  logic [6:0]       cur_char;

  assign emit          = active_q & (!out_valid_q | out_ready_i);
  assign last_in_phase = ((cnt_q + 1'b1) == phase_len(job_i, phase_q));
  assign nxt           = next_phase(job_i, phase_q);
  assign first         = next_phase(job_i, sdtf_pkg::PH_PRE);
  assign is_final      = last_in_phase & !nxt.found;

  // Pick the character for the current position
  always_comb begin
    case (phase_q)
      sdtf_pkg::PH_SIGN:  cur_char = job_i.sign_neg ? sdtf_pkg::CH_MINUS : sdtf_pkg::CH_PLUS;
      sdtf_pkg::PH_MID:   cur_char = sdtf_pkg::CH_ZERO;
      sdtf_pkg::PH_DIGIT: cur_char = sdtf_pkg::CH_ZERO | {3'b000, job_i.digits[cnt_q[3:0]]};
      default:            cur_char = sdtf_pkg::CH_SPACE;
    endcase
  end

  // Walk the phases of the head request, one character per cycle while the sink is ready
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    char_d      = char_q;
    final_d     = final_q;
    pop_o       = 1'b0;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (!active_q) begin
      if (!empty_i) begin
        active_d = 1'b1;
        cnt_d    = '0;
        phase_d  = (phase_len(job_i, sdtf_pkg::PH_PRE) != '0) ? sdtf_pkg::PH_PRE : first.ph;
      end
    end else if (emit) begin
      out_valid_d = 1'b1;
      char_d      = cur_char;
      final_d     = is_final;
      if (is_final) begin
        pop_o    = 1'b1;
        active_d = 1'b0;
      end else if (last_in_phase) begin
        phase_d = nxt.ph;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sdtf_pkg::PH_PRE;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    final_q <= final_d;
  end

  assign out_valid_o  = out_valid_q;
  assign text_char_o  = char_q;
  assign final_char_o = final_q;

  a_active_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !empty_i)
    else $error("emitting without a queued request");

  a_final_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_final) |=> !active_q)
    else $error("request still active after its last character");

endmodule

>>> rtl/core/signed_decimal_text_formatter_unit.sv
// Prints a signed 32-bit value as printf-style decimal text, one ASCII character per
// output request, with final_char_o high on the last character of each field. The front
// converts the magnitude by repeated division by ten through reciprocal multiplication,
// one multiply state and one remainder state per digit (up to 10 digits), and queues the
// result in a two-entry queue. The back emits the field, which is max(pad width capped
// at MAX_FIELD, text length) characters long (1 to max(MAX_FIELD, 11)), at one character
// per cycle while the sink is ready, after a start step for each value, and the front
// converts the next value alongside.
module signed_decimal_text_formatter_unit #(
  parameter int unsigned MAX_FIELD = sdtf_pkg::MAX_FIELD_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_i,
  input  logic [2:0]         style_bits_i,
  input  logic [5:0]         pad_width_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [6:0]         text_char_o,
  output logic               final_char_o
);

  sdtf_pkg::job_t push_job;
  sdtf_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Accept and convert
  sdtf_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .style_bits_i(style_bits_i),
    .pad_width_i (pad_width_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  // Decouple conversion from emission
  sdtf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_job),
    .full_o (full),
    .pop_i  (pop),
    .entry_o(head_job),
    .empty_o(empty)
  );

  // Emit characters
  sdtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .final_char_o(final_char_o)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FIELD_CAP   = sdtf_pkg::MAX_FIELD_DEF;
  localparam int unsigned DIR_ROWS    = 24;
  localparam int unsigned RAND_ITEMS  = 250;
  localparam int unsigned CALM_ITEMS  = 40;      // trailing requests with no idling
  localparam int unsigned HOLD_CYCLES = 300;     // long sink hold-off
  localparam int unsigned HOLD_AFTER  = 80;      // accepted requests before the hold-off
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PRINT_CAP   = 50;

  // Style flags, combined with OR
  localparam logic [2:0] FMT_NONE = 3'b000;
  localparam logic [2:0] FMT_ZERO = 3'b001 << sdtf_pkg::STYLE_ZERO_PAD;
  localparam logic [2:0] FMT_LEFT = 3'b001 << sdtf_pkg::STYLE_LEFT_ADJ;
  localparam logic [2:0] FMT_PLUS = 3'b001 << sdtf_pkg::STYLE_FORCE_SIGN;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  style;
    logic [5:0]  width;
  } fmt_request_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } field_char_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] value_i;
  logic [2:0]         style_bits_i;
  logic [5:0]         pad_width_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [6:0]         text_char_o;
  logic               final_char_o;

  field_char_t expected_chars [$];
  field_char_t exp_char;
  int unsigned mismatches;
  int unsigned accepted_requests;
  int unsigned cycle_count;
  int unsigned sink_stall_left;
  bit          idle_on;
  bit          hold_sink;

  // Directed requests; a non-empty text is the field expected for that row
  fmt_request_t dir_rows [DIR_ROWS] = '{
    '{32'd0,          FMT_NONE,                      6'd0 },
    '{32'd0,          FMT_PLUS,                      6'd0 },
    '{32'h7FFF_FFFF,  FMT_NONE,                      6'd0 },
    '{32'h8000_0000,  FMT_NONE,                      6'd0 },
    '{32'h8000_0000,  FMT_PLUS,                      6'd0 },
    '{32'hFFFF_FFFF,  FMT_NONE,                      6'd5 },
    '{32'd42,         FMT_ZERO,                      6'd6 },
    '{-32'sd42,       FMT_ZERO,                      6'd6 },
    '{32'd42,         FMT_LEFT,                      6'd6 },
    '{32'd42,         FMT_LEFT | FMT_ZERO,           6'd6 },
    '{32'd42,         FMT_PLUS | FMT_LEFT | FMT_ZERO, 6'd6 },
    '{32'd42,         FMT_PLUS | FMT_ZERO,           6'd6 },
    '{32'd12345,      FMT_NONE,                      6'd3 },
    '{32'd12345,      FMT_ZERO,                      6'd5 },
    '{32'd7,          FMT_NONE,                      6'd32 },
    '{32'd7,          FMT_ZERO,                      6'd63 },
    '{32'd7,          FMT_LEFT,                      6'd33 },
    '{32'h8000_0000,  FMT_ZERO,                      6'd40 },
    '{32'h7FFF_FFFF,  FMT_PLUS | FMT_LEFT,           6'd63 },
    '{-32'sd2147483647, FMT_LEFT | FMT_ZERO,         6'd12 },
    '{32'd1000000000, FMT_NONE,                      6'd0 },
    '{32'd9,          FMT_PLUS,                      6'd1 },
    '{32'd999999999,  FMT_PLUS | FMT_ZERO,           6'd11 },
    '{-32'sd10,       FMT_NONE,                      6'd2 }
  };

  string dir_text [DIR_ROWS] = '{
    "0", "+0", "2147483647", "-2147483648", "-2147483648", "   -1",
    "000042", "-00042", "42    ", "42    ", "+42   ", "+00042",
    "12345", "12345", "", "", "", "", "", "",
    "1000000000", "+9", "", "-10"
  };

  signed_decimal_text_formatter_unit #(
    .MAX_FIELD(FIELD_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .style_bits_i(style_bits_i),
    .pad_width_i (pad_width_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .final_char_o(final_char_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Log one mismatch and count it
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Build the expected field of one request, most significant digit first
  function automatic void predict_field(input logic [31:0] raw, input logic [2:0] style,
                                        input logic [5:0] width_in);
    logic [31:0]  mag;
    logic [6:0]   digit_chars [$];
    logic [6:0]   field [$];
    logic [6:0]   sign_ch;
    logic         neg;
    logic         has_sign;
    int unsigned  eff_w;
    int unsigned  text_len;
    int unsigned  pad;
    neg      = raw[31];
    mag      = neg ? (32'd0 - raw) : raw;
    eff_w    = (width_in > FIELD_CAP) ? FIELD_CAP : int'(width_in);
    has_sign = neg || style[sdtf_pkg::STYLE_FORCE_SIGN];
    sign_ch  = neg ? sdtf_pkg::CH_MINUS : sdtf_pkg::CH_PLUS;
    do begin
      digit_chars.push_front(sdtf_pkg::CH_ZERO + 7'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    text_len = digit_chars.size() + (has_sign ? 1 : 0);
    pad      = (eff_w > text_len) ? eff_w - text_len : 0;
    if (style[sdtf_pkg::STYLE_LEFT_ADJ]) begin
      if (has_sign) field.push_back(sign_ch);
      foreach (digit_chars[i]) field.push_back(digit_chars[i]);
      repeat (pad) field.push_back(sdtf_pkg::CH_SPACE);
    end else if (style[sdtf_pkg::STYLE_ZERO_PAD]) begin
      if (has_sign) field.push_back(sign_ch);
      repeat (pad) field.push_back(sdtf_pkg::CH_ZERO);
      foreach (digit_chars[i]) field.push_back(digit_chars[i]);
    end else begin
      repeat (pad) field.push_back(sdtf_pkg::CH_SPACE);
      if (has_sign) field.push_back(sign_ch);
      foreach (digit_chars[i]) field.push_back(digit_chars[i]);
    end
    foreach (field[i]) expected_chars.push_back('{field[i], i == field.size() - 1});
  endfunction

  // Offer one request, wait for acceptance, then record its expected field
  task automatic offer_value(input fmt_request_t req, input string txt);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    value_i      <= req.value;
    style_bits_i <= req.style;
    pad_width_i  <= req.width;
    do @(posedge clk_i); while (!in_ready_o);
    accepted_requests++;
    if (txt.len() == 0) begin
      predict_field(req.value, req.style, req.width);
    end else begin
      for (int i = 0; i < txt.len(); i++) begin
        expected_chars.push_back('{7'(txt[i]), i == txt.len() - 1});
      end
    end
  endtask

  // Random value weighted toward extremes and digit-count boundaries
  function automatic logic [31:0] random_value();
    logic [31:0] pow10;
    logic [31:0] v;
    pow10 = 32'd1;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 99);
      1: begin
        repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
        v = pow10 - 32'($urandom_range(0, 1));
      end
      2: case ($urandom_range(0, 3))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h8000_0001;
        default: v = 32'd0;
      endcase
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) v = 32'd0 - v;
    return v;
  endfunction

  // Sink ready: random stall bursts plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_sink) begin
      out_ready_i <= 1'b0;
    end else if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      out_ready_i     <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_stall_left <= $urandom_range(0, 8);
      out_ready_i     <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Hold the sink off once while requests keep coming
  initial begin
    hold_sink = 1'b0;
    wait (accepted_requests >= HOLD_AFTER);
    @(posedge clk_i);
    hold_sink = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  // Compare every accepted character with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h with nothing expected", text_char_o));
      end else begin
        exp_char = expected_chars.pop_front();
        if (text_char_o !== exp_char.ch) begin
          report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                    text_char_o, exp_char.ch));
        end
        if (final_char_o !== exp_char.last) begin
          report_mismatch($sformatf("final_char %b, expected %b",
                                    final_char_o, exp_char.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset, directed table, random requests, drain
  initial begin
    fmt_request_t req;
    in_valid_i        = 1'b0;
    value_i           = '0;
    style_bits_i      = '0;
    pad_width_i       = '0;
    out_ready_i       = 1'b0;
    rst_ni            = 1'b0;
    mismatches        = 0;
    accepted_requests = 0;
    cycle_count       = 0;
    sink_stall_left   = 0;
    idle_on           = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) offer_value(dir_rows[i], dir_text[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_on   = (i < RAND_ITEMS - CALM_ITEMS);
      req.value = random_value();
      req.style = 3'($urandom_range(0, 7));
      req.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 14));
      offer_value(req, "");
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_chars.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sdtf_pkg.sv
rtl/core/sdtf_front.sv
rtl/core/sdtf_queue.sv
rtl/core/sdtf_back.sv
rtl/core/signed_decimal_text_formatter_unit.sv
dv/testbench.sv
